// ===== hw/rtl/pope_pkg.sv =====
`timescale 1ns / 1ps

package pope_pkg;

    // Payoff kinds
    typedef enum logic [2:0] {
        KIND_EURO     = 3'd0,
        KIND_ASIAN    = 3'd1,
        KIND_UP_OUT   = 3'd2,
        KIND_UP_IN    = 3'd3,
        KIND_DOWN_OUT = 3'd4,
        KIND_DOWN_IN  = 3'd5,
        KIND_LB_FIXED = 3'd6,
        KIND_LB_FLOAT = 3'd7
    } t_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KIND    = 3'd0,
        CFG_IS_CALL = 3'd1,
        CFG_STRIKE  = 3'd2,
        CFG_BARRIER = 3'd3,
        CFG_REBATE  = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_CALC = 2'd2
    } t_back_state;

    localparam int PRICE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int QUOT_STEPS = PRICE_W;

    typedef struct packed {
        logic [31:0] path_price;
        logic        path_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] payoff;
        logic        profitable;
        logic        barrier_was_hit;
        logic        length_overflow;
    } t_out_item;

    // Per-path record handed from front to back (sum and count travel alongside)
    typedef struct packed {
        t_kind              kind;
        logic               is_call;
        logic [PRICE_W-1:0] strike;
        logic [PRICE_W-1:0] rebate;
        logic [PRICE_W-1:0] last;
        logic [PRICE_W-1:0] min_px;
        logic [PRICE_W-1:0] max_px;
        logic               hit;
        logic               overflow;
    } t_path_rec;

endpackage

// ===== hw/rtl/path_option_payoff_evaluator.sv =====
`timescale 1ns / 1ps

// Path option payoff evaluator.
// Input channel (i_valid/o_ready/i_item): one Q16.16 price sample per transaction,
// path_end set on the final sample of a path. Samples are taken one per cycle while o_ready is high.
// Output channel (o_valid/i_ready/o_item): one payoff transaction per finished path.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data): always ready;
// write only while the block is idle. Payoff uses the registers in force on the
// final sample, which are captured with the path record.
// Front keeps min/max/sum/count/barrier flag per sample; on path end it pushes a
// record into a two-entry queue. Back computes the payoff into an output register.
// From the final sample to o_valid a path passes the queue, the back end's IDLE
// and CALC states and the output register; Asian paths also pass DIV, a restoring
// divider giving one quotient bit per cycle. The back end takes one path at a time;
// once the queue fills, o_ready drops until the back end pops a record.
// Reset: config registers give a European call with zero strike, barrier and rebate; queue and output empty.
// A stalled receiver holds the output register; the back end then stops and the
// queue absorbs up to two more finished paths before the input stalls.
module path_option_payoff_evaluator
    import pope_pkg::*;
#(
    parameter int MAX_PATH_LEN = 4096,
    parameter int PRICE_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // count holds MAX_PATH_LEN itself; sum covers that many full-scale prices
    localparam int CNT_W = $clog2(MAX_PATH_LEN + 1);
    localparam int SUM_W = PRICE_W + CNT_W;
    localparam int REC_W = $bits(t_path_rec);
    localparam int Q_W   = REC_W + SUM_W + CNT_W;

    logic             q_push, q_pop, q_full, q_empty;
    t_path_rec        push_rec, head_rec;
    logic [SUM_W-1:0] push_sum, head_sum;
    logic [CNT_W-1:0] push_cnt, head_cnt;
    logic [Q_W-1:0]   q_din, q_dout;

    pope_front #(
        .MAX_PATH_LEN (MAX_PATH_LEN),
        .PRICE_BITS   (PRICE_BITS),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_rec     (push_rec),
        .o_q_sum     (push_sum),
        .o_q_cnt     (push_cnt)
    );

    assign q_din = {push_rec, push_sum, push_cnt};

    pope_fifo #(
        .W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign head_rec = t_path_rec'(q_dout[Q_W-1 -: REC_W]);
    assign head_sum = q_dout[CNT_W +: SUM_W];
    assign head_cnt = q_dout[CNT_W-1:0];

    pope_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_empty),
        .o_q_pop   (q_pop),
        .i_q_rec   (head_rec),
        .i_q_sum   (head_sum),
        .i_q_cnt   (head_cnt),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

// ===== hw/rtl/pope_front.sv =====
`timescale 1ns / 1ps

module pope_front
    import pope_pkg::*;
#(
    parameter int MAX_PATH_LEN = 4096,
    parameter int PRICE_BITS   = 32,
    parameter int CNT_W        = 13,
    parameter int SUM_W        = 45
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_path_rec            o_q_rec,
    output logic [SUM_W-1:0]     o_q_sum,
    output logic [CNT_W-1:0]     o_q_cnt
);

    localparam logic [PRICE_W-1:0] PRICE_MASK =
        (PRICE_BITS >= PRICE_W) ? {PRICE_W{1'b1}}
                                : PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PATH_LEN);

    t_kind              r_kind;
    logic               r_is_call;
    logic [PRICE_W-1:0] r_strike, r_barrier, r_rebate;

    logic [PRICE_W-1:0] r_min, r_max, n_min, n_max;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_touched, n_touched;
    logic               r_ovf, n_ovf;

    logic [PRICE_W-1:0] price;
    logic               accept;
    logic               is_barrier, is_up;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign accept      = i_valid && o_ready;
    assign price       = i_item.path_price & PRICE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_EURO;
            r_is_call <= 1'b1;
            r_strike  <= '0;
            r_barrier <= '0;
            r_rebate  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_KIND:    r_kind    <= t_kind'(i_cfg_data[2:0]);
                CFG_IS_CALL: r_is_call <= i_cfg_data[0];
                CFG_STRIKE:  r_strike  <= i_cfg_data;
                CFG_BARRIER: r_barrier <= i_cfg_data;
                CFG_REBATE:  r_rebate  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_barrier = (r_kind == KIND_UP_OUT) || (r_kind == KIND_UP_IN) ||
                     (r_kind == KIND_DOWN_OUT) || (r_kind == KIND_DOWN_IN);
        is_up      = (r_kind == KIND_UP_OUT) || (r_kind == KIND_UP_IN);

        n_min = (price < r_min) ? price : r_min;
        n_max = (price > r_max) ? price : r_max;
        n_touched = r_touched;
        if (is_barrier && (is_up ? (price >= r_barrier) : (price <= r_barrier))) begin
            n_touched = 1'b1;
        end
        // count saturates at the limit; extra samples stay out of the sum
        if (r_cnt < CNT_LIMIT) begin
            n_sum = r_sum + SUM_W'(price);
            n_cnt = r_cnt + CNT_W'(1);
            n_ovf = r_ovf;
        end else begin
            n_sum = r_sum;
            n_cnt = r_cnt;
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= PRICE_MASK;
            r_max     <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_touched <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (accept) begin
            if (i_item.path_end) begin
                r_min     <= PRICE_MASK;
                r_max     <= '0;
                r_sum     <= '0;
                r_cnt     <= '0;
                r_touched <= 1'b0;
                r_ovf     <= 1'b0;
            end else begin
                r_min     <= n_min;
                r_max     <= n_max;
                r_sum     <= n_sum;
                r_cnt     <= n_cnt;
                r_touched <= n_touched;
                r_ovf     <= n_ovf;
            end
        end
    end

    assign o_q_push = accept && i_item.path_end;
    assign o_q_sum  = n_sum;
    assign o_q_cnt  = n_cnt;

    always_comb begin
        o_q_rec.kind     = r_kind;
        o_q_rec.is_call  = r_is_call;
        o_q_rec.strike   = r_strike;
        o_q_rec.rebate   = r_rebate;
        o_q_rec.last     = price;
        o_q_rec.min_px   = n_min;
        o_q_rec.max_px   = n_max;
        o_q_rec.hit      = is_barrier && n_touched;
        o_q_rec.overflow = n_ovf;
    end

endmodule

// ===== hw/rtl/pope_fifo.sv =====
`timescale 1ns / 1ps

module pope_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    // two-entry queue
    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pope_back.sv =====
`timescale 1ns / 1ps

module pope_back
    import pope_pkg::*;
#(
    parameter int CNT_W = 13,
    parameter int SUM_W = 45
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_path_rec        i_q_rec,
    input  logic [SUM_W-1:0] i_q_sum,
    input  logic [CNT_W-1:0] i_q_cnt,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_item
);

    localparam int STEP_W = $clog2(QUOT_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_STEPS - 1);

    t_back_state r_state, n_state;
    t_path_rec   r_rec;

    // restoring divider: sum / count, one quotient bit per cycle
    logic [CNT_W:0]      r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [PRICE_W-1:0]  r_low;
    logic [PRICE_W-1:0]  r_quot;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W:0]      trial;
    logic                q_bit;

    logic                r_out_valid;
    t_out_item           r_out;

    logic                pop, div_step, load_out, out_free;
    logic [PRICE_W-1:0]  ref_px, vanilla, pay;

    function automatic logic [PRICE_W-1:0] pos_diff(input logic [PRICE_W-1:0] a,
                                                    input logic [PRICE_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_rec.kind == KIND_ASIAN) ? BK_DIV : BK_CALC;
                end
            end
            BK_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = BK_CALC;
                end
            end
            BK_CALC: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop      = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: pop      = i_q_valid;
            BK_DIV:  div_step = 1'b1;
            BK_CALC: load_out = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // remainder stays below the divisor, so the trial fits CNT_W+1 bits
    assign trial = {r_rem[CNT_W-1:0], r_low[PRICE_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rec  <= i_q_rec;
            r_rem  <= (CNT_W+1)'(i_q_sum[SUM_W-1:PRICE_W]);
            r_div  <= i_q_cnt;
            r_low  <= i_q_sum[PRICE_W-1:0];
            r_quot <= '0;
            r_step <= '0;
        end else if (div_step) begin
            r_rem  <= q_bit ? (trial - {1'b0, r_div}) : trial;
            r_low  <= {r_low[PRICE_W-2:0], 1'b0};
            r_quot <= {r_quot[PRICE_W-2:0], q_bit};
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_comb begin
        ref_px  = (r_rec.kind == KIND_ASIAN) ? r_quot : r_rec.last;
        vanilla = r_rec.is_call ? pos_diff(ref_px, r_rec.strike)
                                : pos_diff(r_rec.strike, ref_px);
        case (r_rec.kind)
            KIND_EURO, KIND_ASIAN:        pay = vanilla;
            KIND_UP_OUT, KIND_DOWN_OUT:   pay = r_rec.hit ? r_rec.rebate : vanilla;
            KIND_UP_IN, KIND_DOWN_IN:     pay = r_rec.hit ? vanilla : r_rec.rebate;
            KIND_LB_FIXED: pay = r_rec.is_call ? pos_diff(r_rec.max_px, r_rec.strike)
                                               : pos_diff(r_rec.strike, r_rec.min_px);
            KIND_LB_FLOAT: pay = r_rec.is_call ? pos_diff(r_rec.last, r_rec.min_px)
                                               : pos_diff(r_rec.max_px, r_rec.last);
            default:                      pay = vanilla;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.payoff          <= pay;
            r_out.profitable      <= (pay != '0);
            r_out.barrier_was_hit <= r_rec.hit;
            r_out.length_overflow <= r_rec.overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
